// ----- sv/pdwt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdwt_pkg: shared types and constants of the polar PD waypoint tracker
// Field widths, CORDIC constants, command struct and the arctangent table.
// ----------------------------------------------------------------------------
package pdwt_pkg;

  // default CORDIC length (8..32)
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // item field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned THRUST_W = 48;
  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned GAIN_W   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_PROP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_DERIV = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PROP = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_DERIV = 4'd3;

  localparam logic [GAIN_W-1:0] THRUST_PROP_RST = 16'd256;
  localparam logic [GAIN_W-1:0] THRUST_DERIV_RST = 16'd26;
  localparam logic [GAIN_W-1:0] ANGLE_PROP_RST = 16'd256;
  localparam logic [GAIN_W-1:0] ANGLE_DERIV_RST = 16'd26;

  // internal widths
  localparam int unsigned DIST_W     = 32;  // unsigned Q16.16
  localparam int unsigned HEAD_W     = 16;  // signed Q3.13
  localparam int unsigned XY_W       = 52;  // CORDIC x/y, 16 guard bits
  localparam int unsigned Z_W        = 35;  // CORDIC angle, Q.30
  localparam int unsigned ATAN_W     = 31;
  localparam int unsigned STEP_IDX_W = 5;   // atan table index
  localparam int unsigned MUL_W      = 33;  // signed multiplier operands
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned MAG_W      = 54;
  localparam int unsigned TACC_W     = 52;
  localparam int unsigned AACC_W     = 35;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [18:0] PI_Q13 = 19'sd25736;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  // multiplier operations, in issue order
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LO,   // low word of x times 1/K
    MUL_HI,   // high word of x times 1/K
    MUL_TP,   // thrust proportional
    MUL_TD,   // thrust derivative
    MUL_AP,   // angle proportional
    MUL_AD    // angle derivative
  } mul_op_t;

  // controller to datapath
  typedef struct packed {
    logic                  load;      // capture item, form errors
    logic                  prep;      // initial CORDIC rotation
    logic                  iter;      // one CORDIC micro-rotation
    logic [STEP_IDX_W-1:0] step;
    mul_op_t               mul_op;
    logic                  polar;     // finish magnitude and heading
    logic                  out_load;  // load result register, update state
  } pdwt_cmd_t;

  // handshake status seen by the controller
  typedef struct packed {
    logic in_valid;
    logic in_present;
    logic out_ready;
  } pdwt_hs_t;

  // atan(2^-i) in Q.30
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [STEP_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pdwt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdwt_if: item channels of the waypoint tracker
// Valid/ready channels for the waypoint item and for the drive result.
// ----------------------------------------------------------------------------
interface pdwt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdwt_pkg::COORD_W-1:0]   target_x;
  logic signed [pdwt_pkg::COORD_W-1:0]   target_y;
  logic signed [pdwt_pkg::COORD_W-1:0]   current_x;
  logic signed [pdwt_pkg::COORD_W-1:0]   current_y;
  logic                                  target_present;

  modport source (output valid, target_x, target_y, current_x, current_y,
                  target_present, input ready);
  modport sink (input valid, target_x, target_y, current_x, current_y,
                target_present, output ready);
endinterface

interface pdwt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdwt_pkg::THRUST_W-1:0]  thrust_drive;
  logic signed [pdwt_pkg::ANGLE_W-1:0]   angle_drive;
  logic                                  path_error;

  modport source (output valid, thrust_drive, angle_drive, path_error, input ready);
  modport sink (input valid, thrust_drive, angle_drive, path_error, output ready);
endinterface
`default_nettype wire

// ----- sv/pdwt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdwt_ctrl: sequencer of the waypoint tracker
// Steps one item through error capture, CORDIC, the multiply schedule and
// the result register; owns the channel handshakes.
// ----------------------------------------------------------------------------
module pdwt_ctrl #(
  parameter int unsigned CORDIC_STEPS = pdwt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdwt_pkg::pdwt_hs_t   hs,
  output logic                 in_ready,
  output logic                 out_valid,
  output pdwt_pkg::pdwt_cmd_t  cmd
);

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ITER, S_MUL_LO, S_MUL_HI, S_MAG, S_DIST,
    S_TP, S_TD, S_AP, S_AD, S_SUM, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || hs.out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !hs.out_ready;
    cmd           = '0;
    cmd.mul_op    = pdwt_pkg::MUL_NONE;
    cmd.step      = pdwt_pkg::STEP_IDX_W'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (hs.in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hs.in_present ? S_PREP : S_OUT;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_op = pdwt_pkg::MUL_LO;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_op = pdwt_pkg::MUL_HI;
        state_nxt  = S_MAG;
      end
      S_MAG:  state_nxt = S_DIST;
      S_DIST: begin
        cmd.polar = 1'b1;
        state_nxt = S_TP;
      end
      S_TP: begin
        cmd.mul_op = pdwt_pkg::MUL_TP;
        state_nxt  = S_TD;
      end
      S_TD: begin
        cmd.mul_op = pdwt_pkg::MUL_TD;
        state_nxt  = S_AP;
      end
      S_AP: begin
        cmd.mul_op = pdwt_pkg::MUL_AP;
        state_nxt  = S_AD;
      end
      S_AD: begin
        cmd.mul_op = pdwt_pkg::MUL_AD;
        state_nxt  = S_SUM;
      end
      S_SUM:  state_nxt = S_OUT;
      S_OUT: begin
        // wait until the result register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a missing target skips all arithmetic
  a_skip_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && hs.in_valid && !hs.in_present) |=> (state_r == S_OUT))
    else $error("missing-target item did not go straight to output");

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || hs.out_ready))
    else $error("result register overwritten");

  // step index stays inside the CORDIC length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> (cnt_r <= CNT_LAST))
    else $error("CORDIC step index out of range");

  // a new result appears only out of the output state
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result valid raised outside output state");

endmodule
`default_nettype wire

// ----- sv/pdwt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdwt_datapath: arithmetic of the waypoint tracker
// Error saturation, CORDIC vectoring, one shared 33x33 multiplier with
// accumulators, gain registers, PD state and the result register.
// ----------------------------------------------------------------------------
module pdwt_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pdwt_pkg::pdwt_cmd_t                  cmd,
  input  logic signed [pdwt_pkg::COORD_W-1:0]  in_target_x,
  input  logic signed [pdwt_pkg::COORD_W-1:0]  in_target_y,
  input  logic signed [pdwt_pkg::COORD_W-1:0]  in_current_x,
  input  logic signed [pdwt_pkg::COORD_W-1:0]  in_current_y,
  input  logic                                 in_target_present,
  input  logic                                 cfg_we,
  input  logic [pdwt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdwt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic signed [pdwt_pkg::THRUST_W-1:0] out_thrust_drive,
  output logic signed [pdwt_pkg::ANGLE_W-1:0]  out_angle_drive,
  output logic                                 out_path_error
);

  localparam int unsigned CW = pdwt_pkg::COORD_W;
  localparam int unsigned XW = pdwt_pkg::XY_W;
  localparam int unsigned ZW = pdwt_pkg::Z_W;
  localparam int unsigned MW = pdwt_pkg::MUL_W;
  localparam int unsigned HW = pdwt_pkg::HEAD_W;

  // gain registers
  logic [pdwt_pkg::GAIN_W-1:0] thrust_prop_gain_r, thrust_deriv_gain_r;
  logic [pdwt_pkg::GAIN_W-1:0] angle_prop_gain_r, angle_deriv_gain_r;

  // PD state
  logic [pdwt_pkg::DIST_W-1:0] last_distance_r;
  logic signed [HW-1:0]        last_heading_r;

  // per-item working registers
  logic signed [CW-1:0]          ex_r, ey_r;
  logic                          err_r;
  logic                          zero_r;
  logic signed [XW-1:0]          x_r, y_r;
  logic signed [ZW-1:0]          z_r;
  logic signed [pdwt_pkg::PROD_W-1:0] prod_r;
  pdwt_pkg::mul_op_t             prod_op_r;
  logic [pdwt_pkg::MAG_W-1:0]    mag_acc_r;
  logic signed [pdwt_pkg::TACC_W-1:0] tacc_r;
  logic signed [pdwt_pkg::AACC_W-1:0] aacc_r;
  logic [pdwt_pkg::DIST_W-1:0]   dist_r;
  logic signed [HW-1:0]          head_r;

  // result register
  logic signed [pdwt_pkg::THRUST_W-1:0] thrust_r;
  logic signed [pdwt_pkg::ANGLE_W-1:0]  angle_r;
  logic                                 path_error_r;

  assign out_thrust_drive = thrust_r;
  assign out_angle_drive  = angle_r;
  assign out_path_error   = path_error_r;

  // gain register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_prop_gain_r  <= pdwt_pkg::THRUST_PROP_RST;
      thrust_deriv_gain_r <= pdwt_pkg::THRUST_DERIV_RST;
      angle_prop_gain_r   <= pdwt_pkg::ANGLE_PROP_RST;
      angle_deriv_gain_r  <= pdwt_pkg::ANGLE_DERIV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdwt_pkg::REG_THRUST_PROP:  thrust_prop_gain_r  <= cfg_wdata;
        pdwt_pkg::REG_THRUST_DERIV: thrust_deriv_gain_r <= cfg_wdata;
        pdwt_pkg::REG_ANGLE_PROP:   angle_prop_gain_r   <= cfg_wdata;
        pdwt_pkg::REG_ANGLE_DERIV:  angle_deriv_gain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturated position errors
  logic signed [CW:0]   dx_full, dy_full;
  logic signed [CW-1:0] ex_sat, ey_sat;

  always_comb begin
    dx_full = {in_target_x[CW-1], in_target_x} - {in_current_x[CW-1], in_current_x};
    dy_full = {in_target_y[CW-1], in_target_y} - {in_current_y[CW-1], in_current_y};
    if (dx_full[CW] != dx_full[CW-1]) begin
      ex_sat = dx_full[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      ex_sat = dx_full[CW-1:0];
    end
    if (dy_full[CW] != dy_full[CW-1]) begin
      ey_sat = dy_full[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      ey_sat = dy_full[CW-1:0];
    end
  end

  // initial rotation into the right half plane
  logic signed [XW-1:0] x_init, y_init;
  always_comb begin
    x_init = {{(XW-CW-16){ex_r[CW-1]}}, ex_r, 16'd0};
    y_init = {{(XW-CW-16){ey_r[CW-1]}}, ey_r, 16'd0};
  end

  // one CORDIC micro-rotation; y >= 0 counts as positive
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_v;
  always_comb begin
    xs     = x_r >>> cmd.step;
    ys     = y_r >>> cmd.step;
    atan_v = {{(ZW-pdwt_pkg::ATAN_W){1'b0}}, pdwt_pkg::atan_q30(cmd.step)};
  end

  // multiplier operand select
  logic signed [MW-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      pdwt_pkg::MUL_LO: begin
        mul_a = {1'b0, x_r[31:0]};
        mul_b = {1'b0, pdwt_pkg::INV_GAIN_Q32};
      end
      pdwt_pkg::MUL_HI: begin
        mul_a = {{(MW-XW+32){1'b0}}, x_r[XW-1:32]};
        mul_b = {1'b0, pdwt_pkg::INV_GAIN_Q32};
      end
      pdwt_pkg::MUL_TP: begin
        mul_a = {{(MW-pdwt_pkg::GAIN_W){1'b0}}, thrust_prop_gain_r};
        mul_b = {1'b0, dist_r};
      end
      pdwt_pkg::MUL_TD: begin
        mul_a = {{(MW-pdwt_pkg::GAIN_W){1'b0}}, thrust_deriv_gain_r};
        mul_b = {1'b0, dist_r} - {1'b0, last_distance_r};
      end
      pdwt_pkg::MUL_AP: begin
        mul_a = {{(MW-pdwt_pkg::GAIN_W){1'b0}}, angle_prop_gain_r};
        mul_b = {{(MW-HW){head_r[HW-1]}}, head_r};
      end
      pdwt_pkg::MUL_AD: begin
        mul_a = {{(MW-pdwt_pkg::GAIN_W){1'b0}}, angle_deriv_gain_r};
        mul_b = {{(MW-HW){head_r[HW-1]}}, head_r}
              - {{(MW-HW){last_heading_r[HW-1]}}, last_heading_r};
      end
      default: ;
    endcase
  end

  // final magnitude and heading
  logic [pdwt_pkg::DIST_W-1:0] dist_calc;
  logic signed [ZW:0]          z_round;
  logic signed [18:0]          head_q;
  logic signed [HW-1:0]        head_calc;
  always_comb begin
    if (|mag_acc_r[pdwt_pkg::MAG_W-1:48]) begin
      dist_calc = '1;
    end else begin
      dist_calc = mag_acc_r[47:16];
    end
    z_round = {z_r[ZW-1], z_r} + (ZW+1)'(65536);
    head_q  = z_round[ZW:17];
    if (head_q > pdwt_pkg::PI_Q13) begin
      head_calc = HW'(pdwt_pkg::PI_Q13);
    end else if (head_q < -pdwt_pkg::PI_Q13) begin
      head_calc = HW'(-pdwt_pkg::PI_Q13);
    end else begin
      head_calc = head_q[HW-1:0];
    end
  end

  // output forms: floor shift of thrust, saturation of angle
  logic signed [pdwt_pkg::THRUST_W-1:0] thrust_calc;
  logic signed [pdwt_pkg::ANGLE_W-1:0]  angle_calc;
  always_comb begin
    // thrust magnitude stays below 2^42 after the shift
    thrust_calc = {{(pdwt_pkg::THRUST_W-pdwt_pkg::TACC_W+8){tacc_r[pdwt_pkg::TACC_W-1]}},
                   tacc_r[pdwt_pkg::TACC_W-1:8]};
    if (aacc_r[pdwt_pkg::AACC_W-1:31] == '0 || aacc_r[pdwt_pkg::AACC_W-1:31] == '1) begin
      angle_calc = aacc_r[31:0];
    end else if (aacc_r[pdwt_pkg::AACC_W-1]) begin
      angle_calc = {1'b1, 31'd0};
    end else begin
      angle_calc = {1'b0, {31{1'b1}}};
    end
  end

  // multiplier pipeline tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_op_r <= pdwt_pkg::MUL_NONE;
    end else begin
      prod_op_r <= cmd.mul_op;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ex_r  <= ex_sat;
      ey_r  <= ey_sat;
      err_r <= !in_target_present;
    end

    if (cmd.prep) begin
      zero_r <= (ex_r == '0) && (ey_r == '0);
      if (ex_r[CW-1]) begin
        x_r <= -x_init;
        y_r <= -y_init;
        z_r <= ey_r[CW-1] ? -pdwt_pkg::PI_Q30 : pdwt_pkg::PI_Q30;
      end else begin
        x_r <= x_init;
        y_r <= y_init;
        z_r <= '0;
      end
    end else if (cmd.iter) begin
      if (!y_r[XW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end

    prod_r <= mul_a * mul_b;

    // accumulate the product issued in the cycle before
    case (prod_op_r)
      pdwt_pkg::MUL_LO: mag_acc_r <= {{(pdwt_pkg::MAG_W-32){1'b0}}, prod_r[63:32]};
      pdwt_pkg::MUL_HI: mag_acc_r <= mag_acc_r + prod_r[pdwt_pkg::MAG_W-1:0];
      pdwt_pkg::MUL_TP: tacc_r    <= prod_r[pdwt_pkg::TACC_W-1:0];
      pdwt_pkg::MUL_TD: tacc_r    <= tacc_r + prod_r[pdwt_pkg::TACC_W-1:0];
      pdwt_pkg::MUL_AP: aacc_r    <= prod_r[pdwt_pkg::AACC_W-1:0];
      pdwt_pkg::MUL_AD: aacc_r    <= aacc_r + prod_r[pdwt_pkg::AACC_W-1:0];
      default: ;
    endcase

    // zero error gives zero distance and heading
    if (cmd.polar) begin
      dist_r <= zero_r ? '0 : dist_calc;
      head_r <= zero_r ? '0 : head_calc;
    end

    if (cmd.out_load) begin
      thrust_r     <= err_r ? '0 : thrust_calc;
      angle_r      <= err_r ? '0 : angle_calc;
      path_error_r <= err_r;
    end
  end

  // PD state follows each item that had a target
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_distance_r <= '0;
      last_heading_r  <= '0;
    end else if (cmd.out_load && !err_r) begin
      last_distance_r <= dist_r;
      last_heading_r  <= head_r;
    end
  end

endmodule
`default_nettype wire

// ----- sv/polar_pd_waypoint_tracker_core.sv -----
// Sequence: from accept an item passes the initial rotation, the N CORDIC
//   micro-rotations (N = CORDIC_STEPS) and the six products through the
//   single shared multiplier; an item without a target skips them all.
// A new item is taken only once the last result is loaded for output.
// Reset (synchronous, rst_n low): gains return to their defaults, the stored
//   distance and heading clear to zero, no result is pending.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polar_pd_waypoint_tracker_core: polar PD waypoint tracker
// Turns position error into distance and heading by CORDIC vectoring and
// applies PD laws for thrust and steering.
// ----------------------------------------------------------------------------
module polar_pd_waypoint_tracker_core #(
  parameter int unsigned CORDIC_STEPS = pdwt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pdwt_in_if.sink                             in_ch,
  pdwt_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pdwt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdwt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pdwt_pkg::pdwt_cmd_t cmd;
  pdwt_pkg::pdwt_hs_t  hs;
  logic                in_ready;
  logic                out_valid;

  // handshake status to the sequencer
  assign hs.in_valid   = in_ch.valid;
  assign hs.in_present = in_ch.target_present;
  assign hs.out_ready  = out_ch.ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  pdwt_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs        (hs),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pdwt_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_target_x       (in_ch.target_x),
    .in_target_y       (in_ch.target_y),
    .in_current_x      (in_ch.current_x),
    .in_current_y      (in_ch.current_y),
    .in_target_present (in_ch.target_present),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_thrust_drive  (out_ch.thrust_drive),
    .out_angle_drive   (out_ch.angle_drive),
    .out_path_error    (out_ch.path_error)
  );

endmodule
`default_nettype wire
